// ===== hdl/stsg_pkg.sv =====
// ----------------------------------------------------------------------------
// stsg_pkg: shared types and constants of the sine tone sample generator
// cordic widths, arctangent table, register indexes and pipeline tag
// ----------------------------------------------------------------------------
package stsg_pkg;

  // rotation stages and working width of the cordic datapath
  localparam int CORDIC_STAGES = 30;
  localparam int CORDIC_W      = 34;

  // start vector: reciprocal of the cordic gain times 2^30
  localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

  // arctangent of 2^-i in units of 2^-32 of a full turn
  localparam logic [31:0] ATAN_TAB [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // configuration register indexes
  typedef enum logic [7:0] {
    REG_AMPLITUDE   = 8'd0,
    REG_PHASE_STEP  = 8'd1,
    REG_START_PHASE = 8'd2
  } stsg_reg_t;

  typedef logic signed [CORDIC_W-1:0] stsg_cval_t;

  // control that travels with an item through the rotation stages
  typedef struct packed {
    logic        vld;
    logic        neg;
    logic [31:0] idx;
  } stsg_tag_t;

endpackage

// ===== hdl/sine_tone_sample_generator.sv =====
// ----------------------------------------------------------------------------
// sine_tone_sample_generator: pipelined nco sine sample source
// turns a sample index into amplitude * sin(start_phase + phase_step * index)
// ----------------------------------------------------------------------------
// usage
//   input channel: drive in_sample_index and raise start; the item is taken
//   at a rising edge with start high and busy low. busy is low whenever the
//   block is out of reset, so one item can be taken every cycle
//   result channel: out_valid strobes for one cycle with out_sample_value
//   and out_index_echo; the receiver has no way to stall, so results are
//   never held back and every item yields exactly one result, in order
//   pipeline: 3 phase and setup stages, 30 cordic rotation stages and 3
//   scale and round stages
//   throughput: one item per cycle, set by the fully unrolled cordic pipe
//   config port: cfg_valid / cfg_ready with cfg_index and cfg_wdata;
//   index 0 amplitude, 1 phase_step, 2 start_phase, others ignored.
//   write only while no item is in flight
//   reset: synchronous, active low; flushes the pipe and loads amplitude
//   16384, phase_step 42949673 and start_phase 0
// ----------------------------------------------------------------------------
module sine_tone_sample_generator import stsg_pkg::*; #(
  parameter int OUT_WIDTH   = 16,
  parameter int PHASE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 in_sample_index,
  // result channel
  output logic                        out_valid,
  output logic signed [OUT_WIDTH-1:0] out_sample_value,
  output logic [31:0]                 out_index_echo,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_index,
  input  logic [31:0]                 cfg_wdata
);

  // product of cordic sample and 16-bit signed gain
  localparam int PRODW    = CORDIC_W + 16;
  localparam int SCALE_SH = 46 - OUT_WIDTH;
  localparam int LAT      = 6 + CORDIC_STAGES;

  localparam logic signed [PRODW-1:0] RND_BIAS = PRODW'(64'd1 << (SCALE_SH - 1));
  localparam logic signed [PRODW-1:0] OUT_MAX  =
    {{(PRODW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [PRODW-1:0] OUT_MIN  =
    {{(PRODW-OUT_WIDTH+1){1'b1}}, {(OUT_WIDTH-1){1'b0}}};

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  logic in_accept;
  logic cfg_accept;

  // only held off while reset is applied
  assign busy       = ~rst_n;
  assign cfg_ready  = rst_n;
  assign in_accept  = start & ~busy;
  assign cfg_accept = cfg_valid & cfg_ready;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [14:0] amplitude_r;
  logic [31:0] phase_step_r;
  logic [31:0] start_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r   <= 15'd16384;
      phase_step_r  <= 32'd42949673;
      start_phase_r <= 32'd0;
    end else if (cfg_accept) begin
      case (cfg_index)
        REG_AMPLITUDE:   amplitude_r   <= cfg_wdata[14:0];
        REG_PHASE_STEP:  phase_step_r  <= cfg_wdata;
        REG_START_PHASE: start_phase_r <= cfg_wdata;
        default:         ; // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: capture the index
  // --------------------------------------------------------------------------
  logic        vld1_r;
  logic [31:0] idx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_accept;
    end
    idx1_r <= in_sample_index;
  end

  // --------------------------------------------------------------------------
  // stage 2: phase_step * index, kept modulo 2^PHASE_WIDTH
  // --------------------------------------------------------------------------
  logic                   vld2_r;
  logic [31:0]            idx2_r;
  logic [PHASE_WIDTH-1:0] pmul2_r;
  logic [63:0]            pmul_full;

  assign pmul_full = 64'(phase_step_r) * 64'(idx1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    idx2_r  <= idx1_r;
    pmul2_r <= pmul_full[PHASE_WIDTH-1:0];
  end

  // --------------------------------------------------------------------------
  // stage 3: add start phase, align to 32 bits, fold into +-quarter cycle
  // --------------------------------------------------------------------------
  logic [63:0]            sp_ext;
  logic [PHASE_WIDTH-1:0] ph_sum;
  logic [31:0]            ph32;
  logic [31:0]            ph_fold;
  logic                   fold_neg;
  stsg_tag_t              tag3_r;
  stsg_cval_t             z3_r;

  assign sp_ext = 64'(start_phase_r);
  assign ph_sum = pmul2_r + sp_ext[PHASE_WIDTH-1:0];

  if (PHASE_WIDTH >= 32) begin : g_ph_down
    assign ph32 = ph_sum[PHASE_WIDTH-1:PHASE_WIDTH-32];
  end else begin : g_ph_up
    assign ph32 = {ph_sum, {(32-PHASE_WIDTH){1'b0}}};
  end

  // second and third quarter: move by half a cycle and negate the result
  assign fold_neg = ph32[31] ^ ph32[30];
  assign ph_fold  = fold_neg ? {~ph32[31], ph32[30:0]} : ph32;

  always_ff @(posedge clk) begin
    tag3_r.neg <= fold_neg;
    tag3_r.idx <= idx2_r;
    z3_r       <= $signed({{(CORDIC_W-32){ph_fold[31]}}, ph_fold});
    if (!rst_n) begin
      tag3_r.vld <= 1'b0;
    end else begin
      tag3_r.vld <= vld2_r;
    end
  end

  // --------------------------------------------------------------------------
  // rotation stages
  // --------------------------------------------------------------------------
  stsg_tag_t  tag_c;
  stsg_cval_t y_c;

  stsg_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag3_r),
    .z_in    (z3_r),
    .tag_out (tag_c),
    .y_out   (y_c)
  );

  // --------------------------------------------------------------------------
  // stage 4: restore the sign from the quadrant fold
  // --------------------------------------------------------------------------
  logic       vld4_r;
  logic [31:0] idx4_r;
  stsg_cval_t sin4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= tag_c.vld;
    end
    idx4_r <= tag_c.idx;
    sin4_r <= tag_c.neg ? -y_c : y_c;
  end

  // --------------------------------------------------------------------------
  // stage 5: apply the gain
  // --------------------------------------------------------------------------
  logic                    vld5_r;
  logic [31:0]             idx5_r;
  logic signed [PRODW-1:0] mul5_r;
  logic signed [PRODW-1:0] mul_nxt;

  assign mul_nxt = PRODW'(sin4_r) * PRODW'($signed({1'b0, amplitude_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= vld4_r;
    end
    idx5_r <= idx4_r;
    mul5_r <= mul_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 6: round half up, saturate, drive the result
  // --------------------------------------------------------------------------
  logic signed [PRODW-1:0]     rnd_sum;
  logic signed [PRODW-1:0]     rnd_shift;
  logic signed [OUT_WIDTH-1:0] val_nxt;
  logic                        out_vld_r;
  logic [31:0]                 out_idx_r;
  logic signed [OUT_WIDTH-1:0] out_val_r;

  assign rnd_sum   = mul5_r + RND_BIAS;
  assign rnd_shift = rnd_sum >>> SCALE_SH;

  always_comb begin
    if (rnd_shift > OUT_MAX) begin
      val_nxt = OUT_MAX[OUT_WIDTH-1:0];
    end else if (rnd_shift < OUT_MIN) begin
      val_nxt = OUT_MIN[OUT_WIDTH-1:0];
    end else begin
      val_nxt = rnd_shift[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld5_r;
    end
    out_idx_r <= idx5_r;
    out_val_r <= val_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_sample_value = out_val_r;
  assign out_index_echo   = out_idx_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // every result comes from an item taken a fixed latency earlier
  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LAT))
    else $error("result without a matching item");

  // every taken item yields a result after the fixed latency
  a_item_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##LAT out_valid)
    else $error("item lost in the pipe");

  // the echoed index belongs to the item that produced the result
  a_index_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index_echo == $past(in_sample_index, LAT))
    else $error("index echo out of step with its item");

  // zero gain always gives a silent sample
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && amplitude_r == 15'd0) |-> out_sample_value == '0)
    else $error("nonzero sample at zero gain");

endmodule

// ===== hdl/stsg_cordic.sv =====
// ----------------------------------------------------------------------------
// stsg_cordic: pipelined cordic rotator
// one rotation per register stage, returns sin * 2^30 of the input angle
// ----------------------------------------------------------------------------
module stsg_cordic import stsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stsg_tag_t  tag_in,
  input  stsg_cval_t z_in,
  output stsg_tag_t  tag_out,
  output stsg_cval_t y_out
);

  localparam int N = CORDIC_STAGES;

  localparam stsg_cval_t X_START = stsg_cval_t'({{(CORDIC_W-32){1'b0}}, CORDIC_X0});

  // x and z are not needed after the last rotation
  stsg_cval_t x_r   [N-1];
  stsg_cval_t z_r   [N-1];
  stsg_cval_t y_r   [N];
  stsg_tag_t  tag_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    stsg_cval_t x_i;
    stsg_cval_t y_i;
    stsg_cval_t z_i;
    stsg_tag_t  t_i;
    stsg_cval_t y_nxt;
    logic       rot_pos;

    if (i == 0) begin : g_first
      assign x_i = X_START;
      assign y_i = '0;
      assign z_i = z_in;
      assign t_i = tag_in;
    end else begin : g_next
      assign x_i = x_r[i-1];
      assign y_i = y_r[i-1];
      assign z_i = z_r[i-1];
      assign t_i = tag_r[i-1];
    end

    // rotate toward zero residual angle
    assign rot_pos = ~z_i[CORDIC_W-1];
    assign y_nxt   = rot_pos ? y_i + (x_i >>> i) : y_i - (x_i >>> i);

    always_ff @(posedge clk) begin
      y_r[i]       <= y_nxt;
      tag_r[i].neg <= t_i.neg;
      tag_r[i].idx <= t_i.idx;
      if (!rst_n) begin
        tag_r[i].vld <= 1'b0;
      end else begin
        tag_r[i].vld <= t_i.vld;
      end
    end

    if (i < N - 1) begin : g_xz
      stsg_cval_t x_nxt;
      stsg_cval_t z_nxt;
      stsg_cval_t atan_i;

      assign atan_i = $signed({{(CORDIC_W-32){1'b0}}, ATAN_TAB[i]});
      assign x_nxt  = rot_pos ? x_i - (y_i >>> i) : x_i + (y_i >>> i);
      assign z_nxt  = rot_pos ? z_i - atan_i : z_i + atan_i;

      always_ff @(posedge clk) begin
        x_r[i] <= x_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign y_out   = y_r[N-1];
  assign tag_out = tag_r[N-1];

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sine tone sample generator
// drives sample indexes through the command port, reprograms the gain and
// phase registers between phases, predicts every sample with a bit-exact
// cordic of its own and compares each strobed result with the oldest one
// ----------------------------------------------------------------------------
module tb import stsg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = 16;
  localparam int ROT_STAGES   = 30;
  localparam int SCALE_SHIFT  = 46 - SAMPLE_W;
  localparam int PIPE_LATENCY = 36;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  // register indexes the block must ignore
  localparam logic [7:0] REG_SPARE = 8'd3;
  localparam logic [7:0] REG_TOP   = 8'hFF;

  // arctangent of 2^-k in units of 2^-32 of a full turn
  localparam logic [31:0] ROT_ANGLE [ROT_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // one expected sample and the index it belongs to
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [31:0]                idx;
  } tone_sample_t;

  // in-order store of predicted samples
  class sample_book;
    tone_sample_t pending[$];
    int           faults;

    function new();
      faults = 0;
    endfunction

    function void note_item(tone_sample_t want);
      pending.push_back(want);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] value, logic [31:0] idx);
      tone_sample_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("unexpected sample: value %0d index %h", value, idx);
        return;
      end
      want = pending.pop_front();
      if (value !== want.value || idx !== want.idx) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("sample mismatch: expected value %0d index %h, got value %0d index %h",
                   want.value, want.idx, value, idx);
      end
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [31:0] in_sample_index = '0;
  logic        cfg_valid       = 1'b0;
  logic [7:0]  cfg_index       = '0;
  logic [31:0] cfg_wdata       = '0;

  logic                       busy;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample_value;
  logic [31:0]                out_index_echo;
  logic                       cfg_ready;

  // bench copy of the register file, reset values of the block
  logic [14:0] amp_gain     = 15'd16384;
  logic [31:0] phase_inc    = 32'd42949673;
  logic [31:0] phase_origin = 32'd0;

  sample_book book;
  int         quiet_cycles = 0;

  sine_tone_sample_generator #(
    .OUT_WIDTH  (SAMPLE_W),
    .PHASE_WIDTH(32)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_index (in_sample_index),
    .out_valid       (out_valid),
    .out_sample_value(out_sample_value),
    .out_index_echo  (out_index_echo),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // amplitude * sin(origin + inc * idx), rounded and clipped like the block
  function automatic logic signed [SAMPLE_W-1:0] predict_sine_sample(logic [31:0] idx);
    logic [63:0] wide;
    logic [31:0] ph;
    logic        negate;
    longint      z, x, y, xn, s, prod, v;
    int          k;
    wide = 64'(phase_inc) * 64'(idx);
    ph = wide[31:0] + phase_origin;
    // second and third quarter: rotate by half a cycle, flip the sign
    negate = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    if (negate)
      ph = ph - 32'h8000_0000;
    z = longint'($signed(ph));
    x = 64'h26DD3B6A;
    y = 0;
    for (k = 0; k < ROT_STAGES; k++) begin
      if (z >= 0) begin
        xn = x - (y >>> k);
        y  = y + (x >>> k);
        z  = z - longint'(ROT_ANGLE[k]);
      end else begin
        xn = x + (y >>> k);
        y  = y - (x >>> k);
        z  = z + longint'(ROT_ANGLE[k]);
      end
      x = xn;
    end
    s = negate ? -y : y;
    prod = s * longint'(amp_gain);
    // round half up, then clip to the sample range
    v = (prod + (longint'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    if (v > 32767)
      v = 32767;
    if (v < -32768)
      v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic hold_input(int cycles);
    start <= 1'b0;
    repeat (cycles)
      @(posedge clk);
  endtask

  // leave start high so back-to-back items go one per cycle
  task automatic drive_item(logic [31:0] idx, int idle_odds);
    tone_sample_t want;
    start           <= 1'b1;
    in_sample_index <= idx;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    want.value = predict_sine_sample(idx);
    want.idx   = idx;
    book.note_item(want);
    // random gap after the item, never when idle_odds is zero
    if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0)
      hold_input($urandom_range(1, 17));
  endtask

  // cfg_valid stays high across back-to-back writes, close_config lowers it
  task automatic write_reg(logic [7:0] index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (index)
      REG_AMPLITUDE:   amp_gain     = data[14:0];
      REG_PHASE_STEP:  phase_inc    = data;
      REG_START_PHASE: phase_origin = data;
      default: ;
    endcase
  endtask

  task automatic close_config();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // no write while samples are still in the pipe
  task automatic drain_pipe();
    start <= 1'b0;
    while (book.pending.size() != 0)
      @(posedge clk);
  endtask

  // full range, tiny, near a quarter boundary, or near the top
  function automatic logic [31:0] choose_index();
    logic [31:0] base;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: begin
        base = {2'($urandom_range(0, 3)), 30'd0};
        return base + $urandom_range(0, 15) - 8;
      end
      default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [31:0] choose_gain_word();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'h0000_7FFF;
      // high bits beyond the 15-bit register must be dropped
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] choose_step();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // every result is checked at the edge that ends its strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid)
      book.check_result(out_sample_value, out_index_echo);
  end

  // watchdog: any accepted item, result or register write restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int round;
    int n;
    int odds;
    book = new();
    repeat (6)
      @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: half gain, slow tone, zero start phase
    drive_item(32'd0, 0);
    drive_item(32'd1, 0);
    drive_item(32'd25, 0);
    drive_item(32'd75, 3);
    drive_item(32'hFFFF_FFFF, 0);
    drain_pipe();

    // unit step so the index is the phase: quarter boundaries and the peaks;
    // full gain brings the peaks to full scale, out of range writes do nothing
    write_reg(REG_SPARE, 32'h1234_5678);
    write_reg(REG_AMPLITUDE, 32'hABCD_FFFF);
    write_reg(REG_PHASE_STEP, 32'd1);
    write_reg(REG_START_PHASE, 32'd0);
    write_reg(REG_TOP, 32'hFFFF_FFFF);
    close_config();
    drive_item(32'h0000_0000, 0);
    drive_item(32'h2000_0000, 0);
    drive_item(32'h3FFF_FFFF, 0);
    drive_item(32'h4000_0000, 0);
    drive_item(32'h6000_0000, 0);
    drive_item(32'h7FFF_FFFF, 0);
    drive_item(32'h8000_0000, 0);
    drive_item(32'h8000_0001, 0);
    drive_item(32'hBFFF_FFFF, 0);
    drive_item(32'hC000_0000, 0);
    drive_item(32'hE000_0000, 0);
    drive_item(32'hFFFF_FFFF, 0);
    drain_pipe();

    // zero gain, all-ones step and start phase: the sum wraps
    write_reg(REG_AMPLITUDE, 32'h0000_8000);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_START_PHASE, 32'hFFFF_FFFF);
    close_config();
    drive_item(32'd1, 0);
    drive_item(32'hFFFF_FFFF, 0);
    drive_item(32'h1234_5678, 0);
    drain_pipe();

    // smallest nonzero gain, half-cycle step, quarter start
    write_reg(REG_AMPLITUDE, 32'd1);
    write_reg(REG_PHASE_STEP, 32'h8000_0000);
    write_reg(REG_START_PHASE, 32'h4000_0000);
    close_config();
    drive_item(32'd0, 0);
    drive_item(32'd1, 0);
    drain_pipe();

    // random phases, each with its own register setting
    for (round = 0; round < 7; round++) begin
      write_reg(REG_AMPLITUDE, choose_gain_word());
      write_reg(REG_PHASE_STEP, choose_step());
      write_reg(REG_START_PHASE, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      if ($urandom_range(0, 3) == 0)
        write_reg(8'($urandom_range(REG_SPARE, REG_TOP)), $urandom);
      close_config();
      // mix of gap densities; the closing phase runs without gaps
      odds = (round == 6) ? 0 : 2 + 3 * (round % 3);
      for (n = 0; n < 125; n++)
        drive_item(choose_index(), odds);
      drain_pipe();
    end

    // all items taken: let the pipe run empty and catch stray strobes
    repeat (PIPE_LATENCY + 4)
      @(posedge clk);
    if (book.faults == 0 && book.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
